@@ hw/rtl/wf3_pkg.sv @@
// shared types, register indexes, constants and helper functions of the 3x3 window filter
// no dependencies
`timescale 1ns / 1ps
package wf3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int FIFO_DEPTH     = 8;

    // reciprocals for constant division: x/3 = (x*683)>>11, x/9 = (x*7282)>>16
    localparam logic [10:0] RECIP3 = 11'd683;
    localparam logic [15:0] RECIP9 = 16'd7282;

    localparam logic [3:0] REG_FILTER_MODE  = 4'd0;
    localparam logic [3:0] REG_IMAGE_WIDTH  = 4'd1;
    localparam logic [3:0] REG_IMAGE_HEIGHT = 4'd2;
    localparam logic [3:0] REG_AREA_ENABLE  = 4'd3;
    localparam logic [3:0] REG_AREA_X_LOW   = 4'd4;
    localparam logic [3:0] REG_AREA_X_HIGH  = 4'd5;
    localparam logic [3:0] REG_AREA_Y_LOW   = 4'd6;
    localparam logic [3:0] REG_AREA_Y_HIGH  = 4'd7;

    typedef enum logic [2:0] {
        MODE_BOX, MODE_HIGHPASS, MODE_SOBEL, MODE_BINARIZE,
        MODE_MEDIAN, MODE_MIN, MODE_MAX, MODE_PASS
    } mode_t;

    typedef struct packed {
        logic in_area;
        logic last;
    } wf3_ctrl_t;

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

endpackage

@@ hw/rtl/wf3_kernel.sv @@
// filter datapath: takes the registered 3x3 window and produces one output pixel
// depends on wf3_pkg
`timescale 1ns / 1ps
module wf3_kernel (
    input  logic              aclk,
    input  logic              aresetn,
    input  wf3_pkg::mode_t    mode,
    input  logic              in_valid,
    input  wf3_pkg::wf3_ctrl_t in_ctrl,
    input  logic [8:0][7:0]   win,
    output logic              out_valid,
    output logic [7:0]        out_pixel,
    output logic              out_last,
    output logic [1:0]        busy_count
);
    import wf3_pkg::*;

    // stage 3: sums and row sorts
    logic              v3_reg;
    wf3_ctrl_t         ctrl3_reg;
    logic [7:0]        c3_reg;
    logic [11:0]       box3_reg;
    logic signed [11:0] lap3_reg;
    logic signed [10:0] gx3_reg, gy3_reg;
    logic [2:0][7:0]   lo3_reg, mi3_reg, hi3_reg;

    // stage 4: divisions, magnitudes, order statistics
    logic              v4_reg;
    wf3_ctrl_t         ctrl4_reg;
    logic [7:0]        c4_reg, box4_reg, ql4_reg, med4_reg, mn4_reg, mx4_reg;
    logic              lneg4_reg;
    logic [11:0]       sob4_reg;

    // stage 5: output
    logic              v5_reg;
    logic [7:0]        pix5_reg;
    logic              last5_reg;

    logic [11:0] box_next;
    logic signed [11:0] lap_next;
    logic signed [10:0] gx_next, gy_next;
    logic [9:0]  labs_next;
    logic [27:0] boxp_next;
    logic [25:0] lp_next;
    logic [11:0] sob_next;
    logic [7:0]  filt_next;
    logic [10:0] d_next;

    always_comb begin
        int s;
        int l;
        int gx;
        int gy;
        s = 0;
        for (int i = 0; i < 9; i++) begin
            s = s + int'(win[i]);
        end
        l = int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]) - 4 * int'(win[4]);
        gx = -int'(win[0]) + int'(win[2]) - 2 * int'(win[3]) + 2 * int'(win[5])
             - int'(win[6]) + int'(win[8]);
        gy = -int'(win[0]) - 2 * int'(win[1]) - int'(win[2]) + int'(win[6])
             + 2 * int'(win[7]) + int'(win[8]);
        box_next = 12'(s);
        lap_next = 12'(l);
        gx_next  = 11'(gx);
        gy_next  = 11'(gy);
    end

    always_comb begin
        logic [10:0] ax;
        logic [10:0] ay;
        labs_next = lap3_reg[11] ? 10'(-lap3_reg) : 10'(lap3_reg);
        boxp_next = 28'(box3_reg) * 28'(RECIP9);
        lp_next   = 26'(labs_next) * 26'(RECIP9);
        ax = gx3_reg[10] ? 11'(-gx3_reg) : 11'(gx3_reg);
        ay = gy3_reg[10] ? 11'(-gy3_reg) : 11'(gy3_reg);
        sob_next = 12'(ax) + 12'(ay);
    end

    always_comb begin
        d_next = lneg4_reg ? (11'(c4_reg) + 11'(ql4_reg)) : (11'(c4_reg) - 11'(ql4_reg));
        if (d_next[10]) begin
            d_next = -d_next;
        end
        case (mode)
            MODE_BOX:      filt_next = box4_reg;
            MODE_HIGHPASS: filt_next = d_next[7:0];
            MODE_SOBEL:    filt_next = (sob4_reg > 12'd255) ? 8'd64 : sob4_reg[7:0];
            MODE_BINARIZE: begin
                if (sob4_reg < 12'd127) begin
                    filt_next = 8'd0;
                end else if (sob4_reg > 12'd127) begin
                    filt_next = 8'd255;
                end else begin
                    filt_next = 8'd127;
                end
            end
            MODE_MEDIAN:   filt_next = med4_reg;
            MODE_MIN:      filt_next = mn4_reg;
            MODE_MAX:      filt_next = mx4_reg;
            default:       filt_next = c4_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
        ctrl3_reg <= in_ctrl;
        c3_reg    <= win[4];
        box3_reg  <= box_next;
        lap3_reg  <= lap_next;
        gx3_reg   <= gx_next;
        gy3_reg   <= gy_next;
        for (int r = 0; r < 3; r++) begin
            lo3_reg[r] <= min2(min2(win[3*r], win[3*r+1]), win[3*r+2]);
            mi3_reg[r] <= med3(win[3*r], win[3*r+1], win[3*r+2]);
            hi3_reg[r] <= max2(max2(win[3*r], win[3*r+1]), win[3*r+2]);
        end

        ctrl4_reg <= ctrl3_reg;
        c4_reg    <= c3_reg;
        box4_reg  <= boxp_next[23:16];
        ql4_reg   <= lp_next[23:16];
        lneg4_reg <= lap3_reg[11];
        sob4_reg  <= sob_next;
        med4_reg  <= med3(max2(max2(lo3_reg[0], lo3_reg[1]), lo3_reg[2]),
                          med3(mi3_reg[0], mi3_reg[1], mi3_reg[2]),
                          min2(min2(hi3_reg[0], hi3_reg[1]), hi3_reg[2]));
        mn4_reg   <= min2(min2(lo3_reg[0], lo3_reg[1]), lo3_reg[2]);
        mx4_reg   <= max2(max2(hi3_reg[0], hi3_reg[1]), hi3_reg[2]);

        pix5_reg  <= ctrl4_reg.in_area ? filt_next : c4_reg;
        last5_reg <= ctrl4_reg.last;
    end

    assign out_valid  = v5_reg;
    assign out_pixel  = pix5_reg;
    assign out_last   = last5_reg;
    assign busy_count = 2'(v3_reg) + 2'(v4_reg) + 2'(v5_reg);

endmodule

@@ hw/rtl/window_filter_3x3_multimode.sv @@
// top level of the 3x3 window filter: gray conversion, row stores, window, output queue
// depends on wf3_pkg and wf3_kernel
//
// usage:
// - s_axis carries one RGB pixel per transaction in raster order; tuser = flush.
//   after a frame's last pixel, flush transactions drain the remaining width+1 outputs
// - m_axis carries one gray pixel per transaction; tlast marks the frame's last pixel
// - cfg is a register write channel, always ready; write only while the block is idle.
//   writing image_width or image_height restarts the frame
// - throughput: one transaction per cycle, sustained while m_axis is taken each cycle;
//   the row stores are read and written back once per pixel
// - an output becomes valid after the transaction that emits it has passed the memory
//   read, window, three filter stages and output queue registers
// - the output of a pixel is emitted by the transaction width+1 items later
// - when m_axis stalls, an 8-entry output queue fills and s_axis_tready drops
//   once queue plus in-flight items reach its depth; nothing is lost
// - reset clears counters, window and configuration; row stores are not cleared
`timescale 1ns / 1ps
module window_filter_3x3_multimode #(
    parameter int MAX_WIDTH  = wf3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = wf3_pkg::DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    input  logic        s_axis_tuser,   // flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // pixel_out
    output logic        m_axis_tlast,   // frame_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    import wf3_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 4);
    localparam int FW = $clog2(FIFO_DEPTH);
    localparam int OW = $clog2(FIFO_DEPTH + 1);

    mode_t              mode_reg;
    logic [10:0]        width_reg;
    logic [12:0]        height_reg;
    logic               area_en_reg;
    logic signed [12:0] ax_lo_reg, ax_hi_reg, ay_lo_reg, ay_hi_reg;

    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;

    logic [7:0] upper_mem [MAX_WIDTH];
    logic [7:0] middle_mem [MAX_WIDTH];
    logic [7:0] upper_q, middle_q;

    logic          v1_reg, emit1_reg;
    wf3_ctrl_t     ctrl1_reg;
    logic [7:0]    gray1_reg;
    logic [AW-1:0] col1_reg;

    logic [8:0][7:0] nb_reg;
    logic            kv_reg;
    wf3_ctrl_t       kctrl_reg;

    logic       k_valid, k_last;
    logic [7:0] k_pixel;
    logic [1:0] k_busy;

    logic [8:0]    fifo_mem [FIFO_DEPTH];
    logic [FW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OW-1:0] count_reg;
    logic [OW+1:0] occupancy;
    logic          push, pop;

    logic          s_fire, past_end, take, emit, restart;
    logic [9:0]    rgb_sum;
    logic [20:0]   gray_prod;
    logic [7:0]    gray;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_inc;
    wf3_ctrl_t     ctrl_next;

    always_comb begin
        if (width_reg < 11'd3) begin
            eff_w = CW'(3);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            eff_w = CW'(MAX_WIDTH);
        end else begin
            eff_w = CW'(width_reg);
        end
        if (height_reg < 13'd3) begin
            eff_h = RW'(3);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            eff_h = RW'(MAX_HEIGHT);
        end else begin
            eff_h = RW'(height_reg);
        end
    end

    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign past_end  = in_row_reg >= eff_h;
    assign take      = s_fire && (past_end || !s_axis_tuser);
    assign rgb_sum   = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                       + 10'(s_axis_tdata[23:16]);
    assign gray_prod = 21'(rgb_sum) * 21'(RECIP3);
    assign gray      = past_end ? 8'd0 : gray_prod[18:11];
    assign emit      = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
    assign restart   = cfg_valid && cfg_ready &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    always_comb begin
        logic ins;
        ins = out_col_reg != '0 && out_row_reg != '0 &&
              out_col_reg != eff_w - CW'(1) && out_row_reg != eff_h - RW'(1);
        if (ins && area_en_reg) begin
            ins = int'(out_col_reg) > int'(ax_lo_reg) && int'(out_col_reg) < int'(ax_hi_reg) &&
                  int'(out_row_reg) > int'(ay_lo_reg) && int'(out_row_reg) < int'(ay_hi_reg);
        end
        ctrl_next.in_area = ins;
        ctrl_next.last    = out_col_reg == eff_w - CW'(1) && out_row_reg == eff_h - RW'(1);
        col_inc = in_col_reg + CW'(1);
        row_inc = in_row_reg;
        if (col_inc >= eff_w) begin
            col_inc = '0;
            row_inc = in_row_reg + RW'(1);
        end
        if (row_inc > eff_h + RW'(2)) begin
            row_inc = eff_h + RW'(2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_BOX;
            width_reg   <= 11'd1024;
            height_reg  <= 13'd480;
            area_en_reg <= 1'b0;
            ax_lo_reg   <= '0;
            ax_hi_reg   <= '0;
            ay_lo_reg   <= '0;
            ay_hi_reg   <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FILTER_MODE:  mode_reg    <= mode_t'(cfg_data[2:0]);
                REG_IMAGE_WIDTH:  width_reg   <= cfg_data[10:0];
                REG_IMAGE_HEIGHT: height_reg  <= cfg_data;
                REG_AREA_ENABLE:  area_en_reg <= cfg_data[0];
                REG_AREA_X_LOW:   ax_lo_reg   <= cfg_data;
                REG_AREA_X_HIGH:  ax_hi_reg   <= cfg_data;
                REG_AREA_Y_LOW:   ay_lo_reg   <= cfg_data;
                REG_AREA_Y_HIGH:  ay_hi_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (take) begin
            if (emit && ctrl_next.last) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg <= col_inc;
                in_row_reg <= row_inc;
                if (emit) begin
                    if (out_col_reg + CW'(1) >= eff_w) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end
        end
    end

    // row stores: middle written at accept, upper written back in the cycle after
    always_ff @(posedge aclk) begin
        if (take) begin
            upper_q  <= upper_mem[in_col_reg[AW-1:0]];
            middle_q <= middle_mem[in_col_reg[AW-1:0]];
            middle_mem[in_col_reg[AW-1:0]] <= gray;
        end
        if (v1_reg) begin
            upper_mem[col1_reg] <= middle_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            kv_reg <= 1'b0;
            nb_reg <= '0;
        end else begin
            v1_reg <= take;
            kv_reg <= v1_reg && emit1_reg;
            if (v1_reg) begin
                for (int r = 0; r < 3; r++) begin
                    nb_reg[3*r]   <= nb_reg[3*r+1];
                    nb_reg[3*r+1] <= nb_reg[3*r+2];
                end
                nb_reg[2] <= upper_q;
                nb_reg[5] <= middle_q;
                nb_reg[8] <= gray1_reg;
            end
        end
        emit1_reg <= emit;
        ctrl1_reg <= ctrl_next;
        gray1_reg <= gray;
        col1_reg  <= in_col_reg[AW-1:0];
        kctrl_reg <= ctrl1_reg;
    end

    wf3_kernel u_kernel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mode       (mode_reg),
        .in_valid   (kv_reg),
        .in_ctrl    (kctrl_reg),
        .win        (nb_reg),
        .out_valid  (k_valid),
        .out_pixel  (k_pixel),
        .out_last   (k_last),
        .busy_count (k_busy)
    );

    assign push = k_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FW'(1);
            end
            count_reg <= count_reg + OW'(push) - OW'(pop);
        end
        if (push) begin
            fifo_mem[wr_ptr_reg] <= {k_last, k_pixel};
        end
    end

    assign occupancy     = (OW+2)'(count_reg) + (OW+2)'(v1_reg) + (OW+2)'(kv_reg)
                           + (OW+2)'(k_busy);
    assign s_axis_tready = occupancy < (OW+2)'(FIFO_DEPTH);
    assign m_axis_tvalid = count_reg != '0;
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg][7:0];
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg][8];
    assign cfg_ready     = 1'b1;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (OW+2)'(FIFO_DEPTH))
        else $error("output queue plus in-flight items exceed depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |-> count_reg != OW'(FIFO_DEPTH))
        else $error("push into full output queue");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        restart |=> (in_col_reg == '0 && in_row_reg == '0 && out_row_reg == '0))
        else $error("size write did not restart the frame");

    a_window_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |=> $stable(nb_reg))
        else $error("window moved without an item");

endmodule

@@ sim/wf3_window_checker.sv @@
// checker for the 3x3 window filter: predicts every output pixel from the accepted
// input and register transactions and compares it with the m_axis transactions
// depends on wf3_pkg
`timescale 1ns / 1ps
module wf3_window_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [12:0] cfg_data,
    output int          mismatch_count,
    output int          pending_pixels,
    output int          checked_pixels
);
    import wf3_pkg::*;

    typedef struct {
        logic [7:0] pixel;
        logic       last;
    } out_pixel_t;

    out_pixel_t  expected_pixels[$];
    logic [7:0]  upper_row[DEF_MAX_WIDTH];
    logic [7:0]  middle_row[DEF_MAX_WIDTH];
    logic [7:0]  win[9];
    int          in_col, in_row, out_col, out_row;

    mode_t              mode;
    logic [10:0]        width_reg;
    logic [12:0]        height_reg;
    logic               area_en;
    logic signed [12:0] ax_lo, ax_hi, ay_lo, ay_hi;

    assign pending_pixels = expected_pixels.size();

    function automatic int eff_width();
        int w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = height_reg;
        if (h < 3) h = 3;
        if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
        return h;
    endfunction

    function automatic int sobel_mag();
        int gx, gy;
        gx = -win[0] + win[2] - 2 * win[3] + 2 * win[5] - win[6] + win[8];
        gy = -win[0] - 2 * win[1] - win[2] + win[6] + 2 * win[7] + win[8];
        if (gx < 0) gx = -gx;
        if (gy < 0) gy = -gy;
        return gx + gy;
    endfunction

    function automatic logic [7:0] filter_window();
        int p[9];
        int s, v, t;
        for (int i = 0; i < 9; i++) p[i] = win[i];
        case (mode)
            MODE_BOX: begin
                s = 0;
                for (int i = 0; i < 9; i++) s += p[i];
                return 8'(s / 9);
            end
            MODE_HIGHPASS: begin
                s = p[1] + p[3] + p[5] + p[7] - 4 * p[4];
                v = p[4] - s / 9;
                if (v < 0) v = -v;
                return 8'(v);
            end
            MODE_SOBEL: begin
                v = sobel_mag();
                return (v > 255) ? 8'd64 : 8'(v);
            end
            MODE_BINARIZE: begin
                v = sobel_mag();
                if (v < 127) return 8'd0;
                if (v > 127) return 8'd255;
                return 8'd127;
            end
            MODE_MEDIAN, MODE_MIN, MODE_MAX: begin
                for (int i = 0; i < 8; i++)
                    for (int j = 0; j < 8 - i; j++)
                        if (p[j] > p[j + 1]) begin
                            t = p[j];
                            p[j] = p[j + 1];
                            p[j + 1] = t;
                        end
                if (mode == MODE_MEDIAN) return 8'(p[4]);
                if (mode == MODE_MIN) return 8'(p[0]);
                return 8'(p[8]);
            end
            default: return win[4];
        endcase
    endfunction

    task automatic predict_window_output(input logic [23:0] rgb, input logic flush);
        int w, h, col, gray;
        logic emit, in_area;
        out_pixel_t o;
        w = eff_width();
        h = eff_height();
        gray = 0;
        if (in_row < h) begin
            if (flush) return;
            gray = (int'(rgb[7:0]) + int'(rgb[15:8]) + int'(rgb[23:16])) / 3;
        end
        col = in_col;
        for (int r = 0; r < 3; r++) begin
            win[r * 3] = win[r * 3 + 1];
            win[r * 3 + 1] = win[r * 3 + 2];
        end
        win[2] = upper_row[col];
        win[5] = middle_row[col];
        win[8] = 8'(gray);
        upper_row[col] = middle_row[col];
        middle_row[col] = 8'(gray);
        emit = in_row >= 2 || (in_row == 1 && in_col >= 1);
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (in_row > h + 2) in_row = h + 2;
        if (!emit) return;
        in_area = out_col != 0 && out_row != 0 && out_col != w - 1 && out_row != h - 1;
        if (in_area && area_en)
            in_area = out_col > ax_lo && out_col < ax_hi && out_row > ay_lo && out_row < ay_hi;
        o.pixel = in_area ? filter_window() : win[4];
        o.last = out_col == w - 1 && out_row == h - 1;
        expected_pixels.push_back(o);
        if (o.last) begin
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    always @(posedge aclk) begin
        out_pixel_t o;
        if (!aresetn) begin
            for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
                upper_row[i] = 8'd0;
                middle_row[i] = 8'd0;
            end
            for (int i = 0; i < 9; i++) win[i] = 8'd0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            mode = MODE_BOX; width_reg = 11'd1024; height_reg = 13'd480; area_en = 1'b0;
            ax_lo = '0; ax_hi = '0; ay_lo = '0; ay_hi = '0;
            mismatch_count = 0;
            checked_pixels = 0;
            expected_pixels.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FILTER_MODE:  mode = mode_t'(cfg_data[2:0]);
                    REG_IMAGE_WIDTH: begin
                        width_reg = cfg_data[10:0];
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = cfg_data;
                        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
                    end
                    REG_AREA_ENABLE:  area_en = cfg_data[0];
                    REG_AREA_X_LOW:   ax_lo = cfg_data;
                    REG_AREA_X_HIGH:  ax_hi = cfg_data;
                    REG_AREA_Y_LOW:   ay_lo = cfg_data;
                    REG_AREA_Y_HIGH:  ay_hi = cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_window_output(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                checked_pixels++;
                if (expected_pixels.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected output transaction: pixel %0d last %0b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    o = expected_pixels.pop_front();
                    if (o.pixel !== m_axis_tdata || o.last !== m_axis_tlast) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected pixel %0d last %0b, got %0d last %0b",
                                     o.pixel, o.last, m_axis_tdata, m_axis_tlast);
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb_top.sv @@
// top of the 3x3 window filter testbench: clock, reset, frame stimulus, register writes,
// random stalls on both channels and the verdict; depends on wf3_pkg and wf3_window_checker
`timescale 1ns / 1ps
module tb_top;
    import wf3_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid, s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid, m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid, cfg_ready;
    logic [3:0]  cfg_index;
    logic [12:0] cfg_data;

    int mismatch_count, pending_pixels, checked_pixels;
    int cycles, sink_stall, pixels_sent, frames_sent, items_sent;
    bit calm;

    window_filter_3x3_multimode DUT (.*);

    wf3_window_checker checker_inst (.*);

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                sink_stall = calm ? 0 : $urandom_range(0, 6);
            if (sink_stall > 0) begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // leaves tvalid high so that a back-to-back transaction needs no second assignment
    task automatic send_pixel(input logic [23:0] rgb, input logic flush);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= rgb;
        s_axis_tuser <= flush;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic [23:0] random_rgb();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return {8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
                       8'($urandom_range(0, 1) * 255)};
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [12:0] random_bound(input int span);
        case ($urandom_range(0, 5))
            0: return 13'h1000;
            1: return 13'h0FFF;
            default: return 13'($urandom_range(0, span + 2) - 1);
        endcase
    endfunction

    // one frame of w*h pixels with the odd ignored flush, then the width+1 drain items
    task automatic send_frame(input int w, input int h, input bit noise);
        for (int i = 0; i < w * h; i++) begin
            if (noise && $urandom_range(0, 19) == 0) send_pixel(random_rgb(), 1'b1);
            send_pixel(random_rgb(), 1'b0);
            pixels_sent++;
        end
        for (int i = 0; i <= w; i++)
            send_pixel(random_rgb(), 1'($urandom_range(0, 2) != 0));
        frames_sent++;
    endtask

    task automatic run_phase(input logic [2:0] mode_val, input logic [10:0] w_reg,
                             input logic [12:0] h_reg, input bit noise);
        int w, h;
        w = (w_reg < 3) ? 3 : (w_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(w_reg);
        h = (h_reg < 3) ? 3 : (h_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(h_reg);
        wait_drained();
        write_reg(REG_FILTER_MODE, {10'($urandom), mode_val});
        write_reg(REG_IMAGE_WIDTH, {2'($urandom), w_reg});
        write_reg(REG_IMAGE_HEIGHT, h_reg);
        write_reg(REG_AREA_ENABLE, 13'($urandom_range(0, 1)));
        write_reg(REG_AREA_X_LOW, random_bound(w));
        write_reg(REG_AREA_X_HIGH, random_bound(w));
        write_reg(REG_AREA_Y_LOW, random_bound(h));
        write_reg(REG_AREA_Y_HIGH, random_bound(h));
        cfg_valid <= 1'b0;
        calm = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(1, 2)) send_frame(w, h, noise);
    endtask

    initial begin
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cycles = 0;
        pixels_sent = 0;
        frames_sent = 0;
        items_sent = 0;
        calm = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every mode including the pass-through one, on the smallest frame and clamped sizes
        for (int m = 0; m < 8; m++)
            run_phase(3'(m), 11'($urandom_range(0, 3)), 13'($urandom_range(0, 3)), 1'b0);
        while (items_sent < 600)
            run_phase(3'($urandom_range(0, 7)), 11'($urandom_range(3, 12)),
                      13'($urandom_range(3, 8)), 1'b1);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("covered %0d frames, %0d pixels in %0d input transactions, over all modes",
                 frames_sent, pixels_sent, items_sent);
        $display("%0d output pixels compared, %0d mismatches", checked_pixels, mismatch_count);
        if (mismatch_count == 0 && pending_pixels == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ window_filter_3x3_multimode.f @@
hw/rtl/wf3_pkg.sv
hw/rtl/wf3_kernel.sv
hw/rtl/window_filter_3x3_multimode.sv
sim/wf3_window_checker.sv
sim/tb_top.sv
